@@ rtl/core/rpa_pkg.sv @@
// Shared constants, codes and types for the reference-counted page allocator.
package rpa_pkg;

    // Sizing
    localparam int NUM_PAGES  = 65536;
    localparam int PAGE_SHIFT = 12;
    localparam int COUNT_BITS = 8;
    localparam int PAGE_BITS  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;

    // Field widths
    localparam int ADDR_W     = 32;
    localparam int KIND_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int REF_W      = 8;
    localparam int FREE_W     = 17;
    localparam int LOW_W      = 16;
    localparam int TOP_W      = 17;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    // Page number taken from an address, and a width wide enough to compare it
    localparam int PN_W  = ADDR_W - PAGE_SHIFT;
    localparam int CMP_A = (PN_W > TOP_W) ? PN_W : TOP_W;
    localparam int CMP_W = (CMP_A > PAGE_BITS + 1) ? CMP_A : PAGE_BITS + 1;

    localparam int RES_BITS   = STATUS_W + ADDR_W + REF_W + FREE_W;
    localparam int OUT_DATA_W = ((RES_BITS + 7) / 8) * 8;

    localparam logic [FREE_W-1:0]     FREE_MAX  = {FREE_W{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [TOP_W-1:0]      TOP_RESET = TOP_W'(65536);

    // Operation kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INC   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DEC   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RDCNT = 3'd4;
    localparam logic [KIND_W-1:0] KIND_RDTOT = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OOM = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOWEST = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 1'd1;

    typedef struct packed {
        logic [FREE_W-1:0]   free_total;
        logic [REF_W-1:0]    ref_count;
        logic [ADDR_W-1:0]   alloc_addr;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

@@ rtl/core/refcounted_page_allocator.sv @@
// Top level of the reference-counted page allocator: config, stores, result register.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tuser kind, tdata page_addr
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata status/alloc_addr/ref_count/free_total
//  cfg       in   i_cfg_we (no wait)            i_cfg_idx, i_cfg_wdata
//
// A transaction is accepted in S_IDLE, which reads the link and count memories
// (registered read); S_EXEC then writes the stores back and loads the result
// register. One transaction is in flight at a time.
// After reset, a clearing pass zeroes the count memory one entry per cycle,
// all NUM_PAGES (65536) entries, with s_axis_tready low. Config writes are taken
// throughout. A full result register holds S_EXEC until it drains.
module refcounted_page_allocator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [rpa_pkg::ADDR_W-1:0]          s_axis_tdata,  // [31:0] page_addr
    input  logic [rpa_pkg::KIND_W-1:0]          s_axis_tuser,  // [2:0] kind
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [1:0] status, [33:2] alloc_addr, [41:34] ref_count, [58:42] free_total, rest 0
    output logic [rpa_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [rpa_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [rpa_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);
    import rpa_pkg::*;

    logic [LOW_W-1:0]      r_lowest;
    logic [TOP_W-1:0]      r_top;
    logic                  r_out_valid;
    t_result               r_out;

    logic                  out_free;
    logic                  res_valid;
    t_result               res;
    logic                  clearing;

    logic                  ref_we;
    logic [PAGE_BITS-1:0]  ref_waddr;
    logic [COUNT_BITS-1:0] ref_wdata;
    logic [COUNT_BITS-1:0] ref_rdata;
    logic                  link_we;
    logic [PAGE_BITS-1:0]  link_wdata;
    logic [PAGE_BITS-1:0]  link_rdata;
    logic                  mem_re;
    logic [PAGE_BITS-1:0]  mem_raddr;
    logic [PAGE_BITS-1:0]  cur_page;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowest <= '0;
            r_top    <= TOP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LOWEST: r_lowest <= i_cfg_wdata[LOW_W-1:0];
                CFG_TOP:    r_top    <= i_cfg_wdata[TOP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign out_free = !r_out_valid || m_axis_tready;

    rpa_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_kind       (s_axis_tuser),
        .i_page_addr  (s_axis_tdata),
        .i_lowest     (r_lowest),
        .i_top        (r_top),
        .i_out_free   (out_free),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .o_clearing   (clearing),
        .o_ref_we     (ref_we),
        .o_ref_waddr  (ref_waddr),
        .o_ref_wdata  (ref_wdata),
        .i_ref_rdata  (ref_rdata),
        .o_link_we    (link_we),
        .o_link_wdata (link_wdata),
        .i_link_rdata (link_rdata),
        .o_re         (mem_re),
        .o_raddr      (mem_raddr),
        .o_page       (cur_page)
    );

    rpa_ram #(
        .DATA_W (COUNT_BITS),
        .ADDR_W (PAGE_BITS),
        .DEPTH  (NUM_PAGES)
    ) u_ref_mem (
        .i_clk   (i_clk),
        .i_we    (ref_we),
        .i_waddr (ref_waddr),
        .i_wdata (ref_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (ref_rdata)
    );

    // next-page links; read data is only used after a push wrote the entry
    rpa_ram #(
        .DATA_W (PAGE_BITS),
        .ADDR_W (PAGE_BITS),
        .DEPTH  (NUM_PAGES)
    ) u_link_mem (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (cur_page),
        .i_wdata (link_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (link_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_out);

    // one transaction in flight: accept is always followed by a busy cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("accepted a transaction while one was in flight");

    // no transactions during the count clearing pass
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !s_axis_tready)
        else $error("ready raised during clearing pass");

    // out of memory only with an empty counter and no address
    a_oom_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out.status == ST_OOM) |->
            (r_out.free_total == '0 && r_out.alloc_addr == '0))
        else $error("out of memory reported with pages listed");

    // bad address leaves no count and no address behind
    a_bad_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out.status == ST_BAD) |->
            (r_out.ref_count == '0 && r_out.alloc_addr == '0))
        else $error("bad address result carries data");

endmodule

@@ rtl/core/rpa_ram.sv @@
// Single-port-write, registered-read RAM used for the link and count stores.
module rpa_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 16,
    parameter int DEPTH  = 65536
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/rpa_ctrl.sv @@
// Sequencer: count clearing pass, address check, read-modify-write of both stores.
module rpa_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [rpa_pkg::KIND_W-1:0]         i_kind,
    input  logic [rpa_pkg::ADDR_W-1:0]         i_page_addr,
    input  logic [rpa_pkg::LOW_W-1:0]          i_lowest,
    input  logic [rpa_pkg::TOP_W-1:0]          i_top,
    input  logic                               i_out_free,
    output logic                               o_res_valid,
    output rpa_pkg::t_result                   o_res,
    output logic                               o_clearing,
    // count store
    output logic                               o_ref_we,
    output logic [rpa_pkg::PAGE_BITS-1:0]      o_ref_waddr,
    output logic [rpa_pkg::COUNT_BITS-1:0]     o_ref_wdata,
    input  logic [rpa_pkg::COUNT_BITS-1:0]     i_ref_rdata,
    // link store
    output logic                               o_link_we,
    output logic [rpa_pkg::PAGE_BITS-1:0]      o_link_wdata,
    input  logic [rpa_pkg::PAGE_BITS-1:0]      i_link_rdata,
    // shared read address, issued on accept
    output logic                               o_re,
    output logic [rpa_pkg::PAGE_BITS-1:0]      o_raddr,
    output logic [rpa_pkg::PAGE_BITS-1:0]      o_page
);
    import rpa_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [PAGE_BITS-1:0]  r_clr_idx;
    logic [KIND_W-1:0]     r_kind;
    logic [PAGE_BITS-1:0]  r_page;
    logic                  r_bad;
    logic [PAGE_BITS-1:0]  r_head, n_head;
    logic [FREE_W-1:0]     r_free_cnt, n_free_cnt;
    logic                  r_nonempty, n_nonempty;

    logic                  accept;
    logic                  advance;
    logic [PN_W-1:0]       pnum;
    logic [CMP_W-1:0]      pnum_cmp;
    logic                  bad_addr;
    logic [PAGE_BITS-1:0]  in_page;

    logic [COUNT_BITS-1:0]        new_cnt;
    logic                         ref_wr;
    logic                         push;
    logic [STATUS_W-1:0]          status;
    logic [ADDR_W-1:0]            alloc_addr;
    logic [COUNT_BITS-1:0]        res_cnt;
    logic [COUNT_BITS+REF_W-1:0]  cnt_ext;
    logic [PAGE_BITS+PAGE_SHIFT+ADDR_W-1:0] addr_ext;

    assign accept  = (r_state == S_IDLE) && i_in_valid;
    assign advance = (r_state == S_EXEC) && i_out_free;

    // Address check happens on the accept cycle and is carried as one flag
    assign pnum     = i_page_addr[ADDR_W-1:PAGE_SHIFT];
    assign pnum_cmp = CMP_W'(pnum);
    assign in_page  = PAGE_BITS'(pnum);
    assign bad_addr = (|i_page_addr[PAGE_SHIFT-1:0])
                    || (pnum_cmp <  CMP_W'(i_lowest))
                    || (pnum_cmp >= CMP_W'(i_top))
                    || (pnum_cmp >= CMP_W'(NUM_PAGES));

    assign o_in_ready = (r_state == S_IDLE);
    assign o_re       = accept;
    assign o_raddr    = (i_kind == KIND_ALLOC) ? r_head : in_page;
    assign o_page     = r_page;
    assign o_clearing = (r_state == S_CLEAR);

    always_comb begin
        new_cnt    = i_ref_rdata;
        ref_wr     = 1'b0;
        push       = 1'b0;
        status     = ST_OK;
        res_cnt    = '0;
        n_head     = r_head;
        n_free_cnt = r_free_cnt;
        n_nonempty = r_nonempty;

        case (r_kind) inside
            KIND_ALLOC: begin
                if (r_nonempty) begin
                    new_cnt    = COUNT_BITS'(1);
                    ref_wr     = 1'b1;
                    res_cnt    = COUNT_BITS'(1);
                    n_head     = i_link_rdata;
                    if (r_free_cnt != '0) begin
                        n_free_cnt = r_free_cnt - FREE_W'(1);
                    end
                    n_nonempty = (n_free_cnt != '0);
                end else begin
                    status = ST_OOM;
                end
            end
            KIND_FREE, KIND_INC, KIND_DEC, KIND_RDCNT: begin
                if (r_bad) begin
                    status = ST_BAD;
                end else begin
                    ref_wr = 1'b1;
                    case (r_kind)
                        KIND_FREE: begin
                            if (i_ref_rdata > COUNT_BITS'(1)) begin
                                new_cnt = i_ref_rdata - COUNT_BITS'(1);
                            end else begin
                                new_cnt    = '0;
                                push       = 1'b1;
                                n_head     = r_page;
                                n_nonempty = 1'b1;
                                if (r_free_cnt != FREE_MAX) begin
                                    n_free_cnt = r_free_cnt + FREE_W'(1);
                                end
                            end
                        end
                        KIND_INC: begin
                            if (i_ref_rdata != COUNT_MAX) begin
                                new_cnt = i_ref_rdata + COUNT_BITS'(1);
                            end
                        end
                        KIND_DEC: begin
                            if (i_ref_rdata != '0) begin
                                new_cnt = i_ref_rdata - COUNT_BITS'(1);
                            end
                        end
                        default: begin
                            new_cnt = i_ref_rdata;
                        end
                    endcase
                    res_cnt = new_cnt;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    assign addr_ext   = {{ADDR_W{1'b0}}, r_page, {PAGE_SHIFT{1'b0}}};
    assign alloc_addr = (r_kind == KIND_ALLOC && r_nonempty) ? addr_ext[ADDR_W-1:0] : '0;
    assign cnt_ext    = {{REF_W{1'b0}}, res_cnt};

    assign o_res_valid      = advance;
    assign o_res.status     = status;
    assign o_res.alloc_addr = alloc_addr;
    assign o_res.ref_count  = cnt_ext[REF_W-1:0];
    assign o_res.free_total = n_free_cnt;

    // Count store: clearing pass after reset, else the operation's write-back
    assign o_ref_we     = (r_state == S_CLEAR) || (advance && ref_wr);
    assign o_ref_waddr  = (r_state == S_CLEAR) ? r_clr_idx : r_page;
    assign o_ref_wdata  = (r_state == S_CLEAR) ? '0 : new_cnt;
    assign o_link_we    = advance && push;
    assign o_link_wdata = r_head;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == PAGE_BITS'(NUM_PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (advance) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_idx  <= '0;
            r_head     <= '0;
            r_free_cnt <= '0;
            r_nonempty <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + PAGE_BITS'(1);
            end
            if (advance) begin
                r_head     <= n_head;
                r_free_cnt <= n_free_cnt;
                r_nonempty <= n_nonempty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_kind;
            r_page <= o_raddr;
            r_bad  <= bad_addr;
        end
    end

endmodule
